// File: hw/rtl/mpe_pkg.sv
// shared types and constants of the matrix product engine
package mpe_pkg;

    localparam int IDX_W  = 3;
    localparam int ELEM_W = 10;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int SUM_W  = 23;
    localparam int DIM_W  = 4;
    localparam int CFG_IDX_W = 2;
    localparam int QUEUE_DEPTH = 4;

    // input opcodes
    localparam logic [1:0] OP_LOAD_A  = 2'd0;
    localparam logic [1:0] OP_LOAD_B  = 2'd1;
    localparam logic [1:0] OP_COMPUTE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  row_index;
        logic [IDX_W-1:0]  col_index;
        logic [ELEM_W-1:0] element_value;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] out_row;
        logic [IDX_W-1:0] out_col;
        logic [SUM_W-1:0] dot_sum;
        logic             last;
    } t_out_word;

    typedef enum logic [1:0] {
        K_LOAD_A,
        K_LOAD_B,
        K_COMPUTE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } t_cmd;

    // tags that travel beside the multiply-accumulate pipe
    typedef struct packed {
        logic             is_first;
        logic             is_tail;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_tag;

    typedef enum logic {
        BS_IDLE,
        BS_RUN
    } t_bstate;

endpackage

// File: hw/rtl/mpe_front.sv
// front end: accepts input words, drops meaningless ones, stages commands
module mpe_front #(
    parameter int MAX_DIM = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  mpe_pkg::t_in_word i_in_word,
    output logic              o_cmd_valid,
    input  logic              i_cmd_ready,
    output mpe_pkg::t_cmd     o_cmd
);
    import mpe_pkg::*;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    logic  r_vld, n_vld;
    t_cmd  r_cmd, n_cmd;
    logic  accept;
    logic  in_range;
    logic  keep;
    t_kind kind;

    assign o_in_ready  = !r_vld || i_cmd_ready;
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    assign in_range = ({1'b0, i_in_word.row_index} < MAX_DIM_V)
                   && ({1'b0, i_in_word.col_index} < MAX_DIM_V);

    always_comb begin
        kind = K_COMPUTE;
        keep = 1'b0;
        unique case (i_in_word.op)
            OP_LOAD_A: begin
                kind = K_LOAD_A;
                keep = in_range;
            end
            OP_LOAD_B: begin
                kind = K_LOAD_B;
                keep = in_range;
            end
            OP_COMPUTE: begin
                kind = K_COMPUTE;
                keep = 1'b1;
            end
            default: begin
                kind = K_COMPUTE;
                keep = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_vld = r_vld;
        n_cmd = r_cmd;
        if (accept && keep) begin
            n_vld       = 1'b1;
            n_cmd.kind  = kind;
            n_cmd.row   = i_in_word.row_index;
            n_cmd.col   = i_in_word.col_index;
            n_cmd.value = i_in_word.element_value;
        end else if (i_cmd_ready) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
        r_cmd <= n_cmd;
    end

endmodule

// File: hw/rtl/mpe_queue.sv
// short command queue between front and back end
module mpe_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  mpe_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop,
    output mpe_pkg::t_cmd o_pop_cmd
);
    import mpe_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push, pop;

    assign o_push_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_cmd    = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= PTR_W'(r_wr_ptr + 1'b1);
            end
            if (pop) begin
                r_rd_ptr <= PTR_W'(r_rd_ptr + 1'b1);
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

// File: hw/rtl/mpe_back.sv
// back end: element stores, loop sequencer and multiply-accumulate pipe
module mpe_back #(
    parameter int MAX_DIM = 8
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [mpe_pkg::IDX_W-1:0] i_n_last,
    input  logic [mpe_pkg::IDX_W-1:0] i_m_last,
    input  logic                      i_cmd_valid,
    output logic                      o_cmd_pop,
    input  mpe_pkg::t_cmd             i_cmd,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output mpe_pkg::t_out_word        o_out_word
);
    import mpe_pkg::*;

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [ELEM_W-1:0] r_mem_a [DEPTH];
    logic [ELEM_W-1:0] r_mem_b [DEPTH];

    t_bstate r_state, n_state;
    logic [IDX_W-1:0] r_i, r_j, r_k;
    logic [IDX_W-1:0] n_i, n_j, n_k;

    logic              pop, start, issue, last_issue, en, emit;
    logic              wr_a, wr_b;
    logic [ADDR_W-1:0] wr_addr, a_raddr, b_raddr;

    logic              r_s1_vld, r_s2_vld;
    t_tag              r_s1_tag, r_s2_tag, issue_tag;
    logic [ELEM_W-1:0] r_a_rd, r_b_rd;
    logic [PROD_W-1:0] r_prod;
    logic [SUM_W-1:0]  r_acc, acc_next;

    logic      r_out_vld, n_out_vld;
    t_out_word r_out;

    // pipe halts only when a finished entry cannot leave
    assign en   = !(r_s2_vld && r_s2_tag.is_tail && r_out_vld && !i_out_ready);
    assign emit = r_s2_vld && r_s2_tag.is_tail && en;

    assign last_issue = (r_i == i_n_last) && (r_j == i_n_last) && (r_k == i_m_last);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (i_cmd_valid && i_cmd.kind == K_COMPUTE) begin
                    n_state = BS_RUN;
                end
            end
            BS_RUN: begin
                if (en && last_issue) begin
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        pop   = 1'b0;
        issue = 1'b0;
        unique case (r_state)
            BS_IDLE: pop   = i_cmd_valid;
            BS_RUN:  issue = en;
            default: begin
                pop   = 1'b0;
                issue = 1'b0;
            end
        endcase
    end

    assign o_cmd_pop = pop;
    assign start     = pop && (i_cmd.kind == K_COMPUTE);
    assign wr_a      = pop && (i_cmd.kind == K_LOAD_A);
    assign wr_b      = pop && (i_cmd.kind == K_LOAD_B);
    assign wr_addr   = ADDR_W'(i_cmd.row * MAX_DIM + i_cmd.col);
    assign a_raddr   = ADDR_W'(r_i * MAX_DIM + r_k);
    assign b_raddr   = ADDR_W'(r_k * MAX_DIM + r_j);

    // row, column, inner counters
    always_comb begin
        n_i = r_i;
        n_j = r_j;
        n_k = r_k;
        if (start) begin
            n_i = '0;
            n_j = '0;
            n_k = '0;
        end else if (issue) begin
            if (r_k == i_m_last) begin
                n_k = '0;
                if (r_j == i_n_last) begin
                    n_j = '0;
                    n_i = IDX_W'(r_i + 1'b1);
                end else begin
                    n_j = IDX_W'(r_j + 1'b1);
                end
            end else begin
                n_k = IDX_W'(r_k + 1'b1);
            end
        end
    end

    always_comb begin
        issue_tag.is_first = (r_k == '0);
        issue_tag.is_tail  = (r_k == i_m_last);
        issue_tag.row      = r_i;
        issue_tag.col      = r_j;
        issue_tag.last     = (r_i == i_n_last) && (r_j == i_n_last);
    end

    assign acc_next = r_s2_tag.is_first ? SUM_W'(r_prod) : SUM_W'(r_acc + SUM_W'(r_prod));

    always_comb begin
        n_out_vld = r_out_vld;
        if (emit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (wr_a) begin
            r_mem_a[wr_addr] <= i_cmd.value;
        end
        if (en) begin
            r_a_rd <= r_mem_a[a_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_b) begin
            r_mem_b[wr_addr] <= i_cmd.value;
        end
        if (en) begin
            r_b_rd <= r_mem_b[b_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BS_IDLE;
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (en) begin
                r_s1_vld <= issue;
                r_s2_vld <= r_s1_vld;
            end
        end
        r_i <= n_i;
        r_j <= n_j;
        r_k <= n_k;
        if (en) begin
            r_s1_tag <= issue_tag;
            r_s2_tag <= r_s1_tag;
            r_prod   <= {{(PROD_W-ELEM_W){1'b0}}, r_a_rd} * {{(PROD_W-ELEM_W){1'b0}}, r_b_rd};
            if (r_s2_vld) begin
                r_acc <= acc_next;
            end
        end
        if (emit) begin
            r_out.out_row <= r_s2_tag.row;
            r_out.out_col <= r_s2_tag.col;
            r_out.dot_sum <= acc_next;
            r_out.last    <= r_s2_tag.last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// File: hw/rtl/matrix_product_engine_core.sv
// top level of the matrix product engine: config registers, front, queue, back
//
//  channel   direction  handshake                 contents
//  in        input      i_in_valid / o_in_ready   t_in_word: op, row, col, element
//  out       output     o_out_valid / i_out_ready t_out_word: row, col, dot_sum, last
//  cfg       input      i_cfg_we (no wait)        index i_cfg_idx, data i_cfg_data
//
// load words are accepted back to back while the queue has room
// a compute word runs num_rows * num_rows * inner_dim multiply-accumulates in the back end,
//   one multiply-accumulate per cycle while the output does not stall, set by the single
//   read port of each element store and the one shared multiplier; each product passes the
//   store read registers and the product register, and each sum lands in the output register
// synchronous active-low reset clears valid flags, state and queue pointers, and sets config
//   registers to 8; the element stores are not cleared and hold garbage until written
// a stalled output holds the whole multiply pipe once the next finished entry reaches
//   the last pipe stage; the front keeps taking words until the command queue fills
module matrix_product_engine_core #(
    parameter int MAX_DIM = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  mpe_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output mpe_pkg::t_out_word            o_out_word,
    input  logic                          i_cfg_we,
    input  logic [mpe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mpe_pkg::DIM_W-1:0]     i_cfg_data
);
    import mpe_pkg::*;

    localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);

    // configuration registers
    logic [DIM_W-1:0] r_num_rows, r_inner_dim;
    logic [DIM_W-1:0] rows_eff, inner_eff;
    logic [IDX_W-1:0] n_last, m_last;

    // front to queue
    logic q_push_vld, q_push_rdy;
    t_cmd q_push_cmd;
    // queue to back
    logic q_pop_vld, q_pop;
    t_cmd q_pop_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_rows  <= 4'd8;
            r_inner_dim <= 4'd8;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NUM_ROWS:  r_num_rows  <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero counts as one, anything above the store size as the store size
    always_comb begin
        rows_eff = r_num_rows;
        if (r_num_rows == '0) begin
            rows_eff = DIM_W'(1);
        end else if (r_num_rows > MAX_DIM_V) begin
            rows_eff = MAX_DIM_V;
        end
        inner_eff = r_inner_dim;
        if (r_inner_dim == '0) begin
            inner_eff = DIM_W'(1);
        end else if (r_inner_dim > MAX_DIM_V) begin
            inner_eff = MAX_DIM_V;
        end
    end

    // loop bounds as last index values
    assign n_last = IDX_W'(rows_eff - 1'b1);
    assign m_last = IDX_W'(inner_eff - 1'b1);

    mpe_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_cmd_valid (q_push_vld),
        .i_cmd_ready (q_push_rdy),
        .o_cmd       (q_push_cmd)
    );

    mpe_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (q_push_vld),
        .o_push_ready (q_push_rdy),
        .i_push_cmd   (q_push_cmd),
        .o_pop_valid  (q_pop_vld),
        .i_pop        (q_pop),
        .o_pop_cmd    (q_pop_cmd)
    );

    mpe_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n_last    (n_last),
        .i_m_last    (m_last),
        .i_cmd_valid (q_pop_vld),
        .o_cmd_pop   (q_pop),
        .i_cmd       (q_pop_cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

`ifndef SYNTHESIS
    // the final entry always sits on the diagonal corner
    a_last_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.last) |-> (o_out_word.out_row == o_out_word.out_col))
        else $error("last entry off the diagonal");

    // nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // an empty front stage must always take a word
    a_front_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_push_vld |-> o_in_ready)
        else $error("front stalled while empty");

    // the back end never pops an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_pop_vld)
        else $error("pop from empty queue");
`endif

endmodule
